/* rtl/spi_flash_command_engine_top_defines.svh */
// assertion macros for the spi flash command engine
`ifndef SPI_FLASH_COMMAND_ENGINE_TOP_DEFINES_SVH
`define SPI_FLASH_COMMAND_ENGINE_TOP_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define SFC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define SFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sfce_pkg.sv */
// ----------------------------------------------------------------------------
// sfce_pkg
// shared types and constants of the spi flash command engine
// ----------------------------------------------------------------------------
`default_nettype none
package sfce_pkg;

  localparam logic [15:0] PollLimitReset = 16'd10000;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    REQ_TICK  = 3'd0,
    REQ_ERASE = 3'd1,
    REQ_PROG  = 3'd2,
    REQ_READ  = 3'd3,
    REQ_DATA  = 3'd4,
    REQ_WREN  = 3'd5,
    REQ_WRDI  = 3'd6,
    REQ_WAIT  = 3'd7
  } req_t;

  localparam logic [7:0] CMD_WREN = 8'h06;
  localparam logic [7:0] CMD_WRDI = 8'h04;
  localparam logic [7:0] CMD_RDSR = 8'h05;
  localparam logic [7:0] CMD_SE   = 8'h20;
  localparam logic [7:0] CMD_PP   = 8'h02;
  localparam logic [7:0] CMD_READ = 8'h03;
  localparam logic [7:0] FILL_ONE = 8'hFF;

  // classified request handed from the front to the back
  typedef struct packed {
    req_t        kind;
    logic [23:0] address;
    logic [15:0] byte_count;
    logic [7:0]  data_byte;
    logic        miso;
  } item_t;

  // one result
  typedef struct packed {
    logic       cs_n;
    logic       sck;
    logic       mosi;
    logic       need_data;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       busy_res;
    logic       done_res;
    logic       timed_out;
  } res_t;

endpackage
`default_nettype wire

/* rtl/spi_flash_command_engine_top.sv */
// ----------------------------------------------------------------------------
// spi_flash_command_engine_top
// spi mode 0 nor flash command engine with request queue
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  in      | in_valid/in_ready   | req_type address byte_count data_byte miso
//  out     | out_valid/out_ready | cs_n sck mosi need_data read_valid ...
//  cfg     | cfg_we              | cfg_wdata (busy poll limit)
// one request per cycle while the queue has room; each request yields one result via the queue and the result register
// a two-entry queue between intake and sequencer absorbs output stalls
// synchronous reset: no result valid, chip select register high, sck low, poll limit 10000
// ----------------------------------------------------------------------------
`default_nettype none
`include "spi_flash_command_engine_top_defines.svh"
module spi_flash_command_engine_top #(
  parameter int unsigned QueueDepth = sfce_pkg::QueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  req_type,
  input  wire logic [23:0] address,
  input  wire logic [15:0] byte_count,
  input  wire logic [7:0]  data_byte,
  input  wire logic        miso,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             cs_n,
  output logic             sck,
  output logic             mosi,
  output logic             need_data,
  output logic             read_valid,
  output logic [7:0]       read_byte,
  output logic             busy_res,
  output logic             done_res,
  output logic             timed_out
);
  logic q_valid, q_ready;
  sfce_pkg::item_t q_item;
  sfce_pkg::res_t  r_data;

  // intake
  sfce_front #(.Depth(QueueDepth)) u_front (
    .clk, .rst, .in_valid, .in_ready, .req_type, .address, .byte_count,
    .data_byte, .miso, .q_valid, .q_ready, .q_item
  );

  // sequencer
  sfce_back u_back (
    .clk, .rst, .cfg_we, .cfg_wdata, .q_valid, .q_ready, .q_item,
    .r_valid(out_valid), .r_ready(out_ready), .r_data
  );

  assign cs_n       = r_data.cs_n;
  assign sck        = r_data.sck;
  assign mosi       = r_data.mosi;
  assign need_data  = r_data.need_data;
  assign read_valid = r_data.read_valid;
  assign read_byte  = r_data.read_byte;
  assign busy_res   = r_data.busy_res;
  assign done_res   = r_data.done_res;
  assign timed_out  = r_data.timed_out;

  // result consistency checks
  `SFC_ASSERT_IMPL(a_to_done, out_valid && timed_out, done_res, "timeout without done")
  `SFC_ASSERT_IMPL(a_done_idle, out_valid && done_res, !busy_res && cs_n, "done while busy")
  `SFC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
endmodule
`default_nettype wire

/* rtl/sfce_front.sv */
// ----------------------------------------------------------------------------
// sfce_front
// request intake and a short queue toward the command sequencer
// ----------------------------------------------------------------------------
`default_nettype none
module sfce_front #(
  parameter int unsigned Depth = sfce_pkg::QueueDepth
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [2:0]    req_type,
  input  wire logic [23:0]   address,
  input  wire logic [15:0]   byte_count,
  input  wire logic [7:0]    data_byte,
  input  wire logic          miso,
  output logic               q_valid,
  input  wire logic          q_ready,
  output sfce_pkg::item_t    q_item
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  sfce_pkg::item_t mem [Depth];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;
  logic push, pop;
  sfce_pkg::item_t cls;

  // classify the incoming request
  always_comb begin
    cls.kind       = sfce_pkg::req_t'(req_type);
    cls.address    = address;
    cls.byte_count = byte_count;
    cls.data_byte  = data_byte;
    cls.miso       = miso;
  end

  assign in_ready = (count != (AW+1)'(Depth));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign pop      = q_valid && q_ready;
  assign q_item   = mem[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= cls;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(Depth-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(Depth-1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

/* rtl/sfce_back.sv */
// ----------------------------------------------------------------------------
// sfce_back
// command sequencer and pin engine, one queued request per cycle while the result register can take it
// ----------------------------------------------------------------------------
`default_nettype none
module sfce_back (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  wire sfce_pkg::item_t q_item,
  output logic             r_valid,
  input  wire logic        r_ready,
  output sfce_pkg::res_t   r_data
);
  typedef enum logic [3:0] {
    ST_IDLE, ST_ONEBYTE, ST_CMD, ST_A2, ST_A1, ST_A0, ST_WAITDATA,
    ST_PDATA, ST_RDATA, ST_POLLCMD, ST_POLL, ST_GAPCMD, ST_GAPPOLL
  } state_t;

  state_t      op_state, op_state_next;
  logic [2:0]  pending_op, pending_op_next;
  logic [7:0]  tx_shift, tx_shift_next, rx_shift, rx_shift_next;
  logic [2:0]  bit_index, bit_index_next;
  logic        clock_phase, clock_phase_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [23:0] target_address, target_address_next;
  logic [15:0] polls_left, polls_left_next;
  logic        sck_level, sck_level_next, mosi_level, mosi_level_next;
  logic        select_n, select_n_next;
  logic [15:0] poll_limit;
  logic        step;
  logic        d_done, d_to, d_valid;
  logic [7:0]  d_byte;
  logic [15:0] dec_bytes, dec_polls;
  sfce_pkg::req_t k;

  // output register may be refilled while taken
  assign q_ready = !r_valid || r_ready;
  assign step    = q_valid && q_ready;
  assign k       = q_item.kind;
  assign dec_bytes = bytes_left - 16'd1;
  assign dec_polls = polls_left - 16'd1;

  // next state of the sequencer for one request
  always_comb begin
    logic [7:0] ld;
    logic       do_load;
    ld = '0;
    do_load = 1'b0;
    op_state_next = op_state;
    pending_op_next = pending_op;
    tx_shift_next = tx_shift;
    rx_shift_next = rx_shift;
    bit_index_next = bit_index;
    clock_phase_next = clock_phase;
    bytes_left_next = bytes_left;
    target_address_next = target_address;
    polls_left_next = polls_left;
    sck_level_next = sck_level;
    mosi_level_next = mosi_level;
    select_n_next = select_n;
    d_done = 1'b0;
    d_to = 1'b0;
    d_valid = 1'b0;
    d_byte = '0;
    if (k == sfce_pkg::REQ_TICK) begin
      unique case (op_state)
        ST_IDLE, ST_WAITDATA: begin
        end
        ST_GAPCMD: begin
          select_n_next = 1'b0;
          ld = (pending_op == sfce_pkg::REQ_ERASE) ? sfce_pkg::CMD_SE : sfce_pkg::CMD_PP;
          do_load = 1'b1;
          op_state_next = ST_CMD;
        end
        ST_GAPPOLL: begin
          select_n_next = 1'b0;
          ld = sfce_pkg::CMD_RDSR;
          do_load = 1'b1;
          op_state_next = ST_POLLCMD;
        end
        default: begin
          if (!clock_phase) begin
            sck_level_next = 1'b1;
            rx_shift_next = {rx_shift[6:0], q_item.miso};
            clock_phase_next = 1'b1;
          end else if (bit_index != 3'd7) begin
            sck_level_next = 1'b0;
            bit_index_next = bit_index + 3'd1;
            tx_shift_next = {tx_shift[6:0], 1'b0};
            mosi_level_next = tx_shift[6];
            clock_phase_next = 1'b0;
          end else begin
            sck_level_next = 1'b0;
            // end of a byte
            priority case (op_state)
              ST_ONEBYTE: begin
                select_n_next = 1'b1;
                if (pending_op == sfce_pkg::REQ_ERASE || pending_op == sfce_pkg::REQ_PROG) begin
                  op_state_next = ST_GAPCMD;
                end else begin
                  op_state_next = ST_IDLE;
                  d_done = 1'b1;
                end
              end
              ST_CMD: begin
                ld = target_address[23:16]; do_load = 1'b1; op_state_next = ST_A2;
              end
              ST_A2: begin
                ld = target_address[15:8]; do_load = 1'b1; op_state_next = ST_A1;
              end
              ST_A1: begin
                ld = target_address[7:0]; do_load = 1'b1; op_state_next = ST_A0;
              end
              ST_A0: begin
                if (pending_op == sfce_pkg::REQ_ERASE) begin
                  select_n_next = 1'b1; op_state_next = ST_GAPPOLL;
                end else if (pending_op == sfce_pkg::REQ_PROG) begin
                  if (bytes_left == '0) begin
                    select_n_next = 1'b1; op_state_next = ST_GAPPOLL;
                  end else begin
                    op_state_next = ST_WAITDATA;
                  end
                end else if (bytes_left == '0) begin
                  select_n_next = 1'b1; op_state_next = ST_IDLE; d_done = 1'b1;
                end else begin
                  ld = sfce_pkg::FILL_ONE; do_load = 1'b1; op_state_next = ST_RDATA;
                end
              end
              ST_PDATA: begin
                bytes_left_next = dec_bytes;
                if (dec_bytes == '0) begin
                  select_n_next = 1'b1; op_state_next = ST_GAPPOLL;
                end else begin
                  op_state_next = ST_WAITDATA;
                end
              end
              ST_RDATA: begin
                d_valid = 1'b1;
                d_byte = rx_shift;
                bytes_left_next = dec_bytes;
                if (dec_bytes == '0) begin
                  select_n_next = 1'b1; op_state_next = ST_IDLE; d_done = 1'b1;
                end else begin
                  ld = sfce_pkg::FILL_ONE; do_load = 1'b1;
                end
              end
              ST_POLLCMD: begin
                polls_left_next = (poll_limit == '0) ? 16'd1 : poll_limit;
                ld = sfce_pkg::CMD_RDSR; do_load = 1'b1; op_state_next = ST_POLL;
              end
              ST_POLL: begin
                polls_left_next = dec_polls;
                if (!rx_shift[0]) begin
                  select_n_next = 1'b1; op_state_next = ST_IDLE; d_done = 1'b1;
                end else if (dec_polls == '0) begin
                  select_n_next = 1'b1; op_state_next = ST_IDLE;
                  d_done = 1'b1; d_to = 1'b1;
                end else begin
                  ld = sfce_pkg::CMD_RDSR; do_load = 1'b1;
                end
              end
              default: begin
                select_n_next = 1'b1; op_state_next = ST_IDLE;
              end
            endcase
          end
        end
      endcase
    end else if (k == sfce_pkg::REQ_DATA) begin
      if (op_state == ST_WAITDATA) begin
        ld = q_item.data_byte; do_load = 1'b1; op_state_next = ST_PDATA;
      end
    end else if (op_state == ST_IDLE) begin
      pending_op_next = k;
      target_address_next = q_item.address;
      bytes_left_next = q_item.byte_count;
      select_n_next = 1'b0;
      sck_level_next = 1'b0;
      do_load = 1'b1;
      priority case (k)
        sfce_pkg::REQ_ERASE, sfce_pkg::REQ_PROG, sfce_pkg::REQ_WREN: begin
          ld = sfce_pkg::CMD_WREN; op_state_next = ST_ONEBYTE;
        end
        sfce_pkg::REQ_WRDI: begin
          ld = sfce_pkg::CMD_WRDI; op_state_next = ST_ONEBYTE;
        end
        sfce_pkg::REQ_READ: begin
          ld = sfce_pkg::CMD_READ; op_state_next = ST_CMD;
        end
        default: begin
          ld = sfce_pkg::CMD_RDSR; op_state_next = ST_POLLCMD;
        end
      endcase
    end
    if (do_load) begin
      tx_shift_next = ld;
      rx_shift_next = '0;
      bit_index_next = '0;
      clock_phase_next = 1'b0;
      mosi_level_next = ld[7];
    end
  end

  // sequencer state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      op_state <= ST_IDLE;
      pending_op <= '0;
      tx_shift <= '0;
      rx_shift <= '0;
      bit_index <= '0;
      clock_phase <= 1'b0;
      bytes_left <= '0;
      target_address <= '0;
      polls_left <= '0;
      sck_level <= 1'b0;
      mosi_level <= 1'b0;
      select_n <= 1'b1;
      poll_limit <= sfce_pkg::PollLimitReset;
      r_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        poll_limit <= cfg_wdata;
      end
      if (step) begin
        op_state <= op_state_next;
        pending_op <= pending_op_next;
        tx_shift <= tx_shift_next;
        rx_shift <= rx_shift_next;
        bit_index <= bit_index_next;
        clock_phase <= clock_phase_next;
        bytes_left <= bytes_left_next;
        target_address <= target_address_next;
        polls_left <= polls_left_next;
        sck_level <= sck_level_next;
        mosi_level <= mosi_level_next;
        select_n <= select_n_next;
        r_valid <= 1'b1;
        r_data.cs_n <= select_n_next;
        r_data.sck <= sck_level_next;
        r_data.mosi <= mosi_level_next;
        r_data.need_data <= (op_state_next == ST_WAITDATA);
        r_data.read_valid <= d_valid;
        r_data.read_byte <= d_byte;
        r_data.busy_res <= (op_state_next != ST_IDLE);
        r_data.done_res <= d_done;
        r_data.timed_out <= d_to;
      end else if (r_ready) begin
        r_valid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

/* verif/tb_spi_flash_command_engine_top.sv */
// ----------------------------------------------------------------------------
// tb_spi_flash_command_engine_top
// self-checking bench for the spi mode 0 nor flash command engine
// ----------------------------------------------------------------------------
// a cycle-level model of the engine predicts the pin levels and flags for
// every accepted request; a monitor compares each result in order. directed
// operations are followed by random well-formed flash sequences with random
// status bytes, run under several idle/stall mixes after a sweep of poll limits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_spi_flash_command_engine_top;

  // engine states of the predictor
  typedef enum int {
    S_IDLE, S_ONEBYTE, S_CMD, S_A2, S_A1, S_A0, S_WAITDATA, S_PDATA, S_RDATA,
    S_POLLCMD, S_POLL, S_GAPCMD, S_GAPPOLL
  } eng_state_t;

  localparam int OpenLatency = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] req_type = '0;
  logic [23:0] address = '0;
  logic [15:0] byte_count = '0;
  logic [7:0] data_byte = '0;
  logic miso = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic cs_n, sck, mosi, need_data, read_valid, busy_res, done_res, timed_out;
  logic [7:0] read_byte;

  spi_flash_command_engine_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
    .address(address), .byte_count(byte_count), .data_byte(data_byte),
    .miso(miso), .out_valid(out_valid), .out_ready(out_ready), .cs_n(cs_n),
    .sck(sck), .mosi(mosi), .need_data(need_data), .read_valid(read_valid),
    .read_byte(read_byte), .busy_res(busy_res), .done_res(done_res),
    .timed_out(timed_out)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end

  // predictor state
  eng_state_t st;
  logic [2:0] p_op;
  logic [7:0] p_tx, p_rx;
  logic [2:0] p_bit;
  logic p_phase, p_sck, p_mosi, p_csn;
  logic [15:0] p_left, p_polls, p_limit;
  logic [23:0] p_addr;
  logic r_done, r_to, r_valid;
  logic [7:0] r_byte;

  sfce_pkg::res_t pin_results_q[$];
  int errors = 0;
  int sent = 0;
  int checked = 0;
  int n_done = 0;
  int n_timeout = 0;
  int n_rbytes = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_len = 0;
  int hold_id = 0;
  int last_hold_id = 0;
  int hold_cycles = 0;

  task automatic shift_load(input logic [7:0] v);
    p_tx = v;
    p_rx = '0;
    p_bit = '0;
    p_phase = 1'b0;
    p_mosi = v[7];
  endtask

  task automatic close_frame(input eng_state_t nxt);
    p_csn = 1'b1;
    p_sck = 1'b0;
    st = nxt;
  endtask

  task automatic finish_op(input logic to);
    close_frame(S_IDLE);
    r_done = 1'b1;
    r_to = to;
  endtask

  // byte boundary sequencing
  task automatic byte_done();
    case (st)
      S_ONEBYTE: begin
        if (p_op == sfce_pkg::REQ_ERASE || p_op == sfce_pkg::REQ_PROG) close_frame(S_GAPCMD);
        else finish_op(1'b0);
      end
      S_CMD: begin shift_load(p_addr[23:16]); st = S_A2; end
      S_A2: begin shift_load(p_addr[15:8]); st = S_A1; end
      S_A1: begin shift_load(p_addr[7:0]); st = S_A0; end
      S_A0: begin
        if (p_op == sfce_pkg::REQ_ERASE) close_frame(S_GAPPOLL);
        else if (p_op == sfce_pkg::REQ_PROG) begin
          if (p_left == 0) close_frame(S_GAPPOLL);
          else st = S_WAITDATA;
        end else begin
          if (p_left == 0) finish_op(1'b0);
          else begin shift_load(sfce_pkg::FILL_ONE); st = S_RDATA; end
        end
      end
      S_PDATA: begin
        p_left = p_left - 16'd1;
        if (p_left == 0) close_frame(S_GAPPOLL);
        else st = S_WAITDATA;
      end
      S_RDATA: begin
        r_valid = 1'b1;
        r_byte = p_rx;
        p_left = p_left - 16'd1;
        if (p_left == 0) finish_op(1'b0);
        else shift_load(sfce_pkg::FILL_ONE);
      end
      S_POLLCMD: begin
        p_polls = (p_limit == 0) ? 16'd1 : p_limit;
        shift_load(sfce_pkg::CMD_RDSR);
        st = S_POLL;
      end
      S_POLL: begin
        p_polls = p_polls - 16'd1;
        if (!p_rx[0]) finish_op(1'b0);
        else if (p_polls == 0) finish_op(1'b1);
        else shift_load(sfce_pkg::CMD_RDSR);
      end
      default: close_frame(S_IDLE);
    endcase
  endtask

  // predict the result of one accepted request
  task automatic predict_pins(input logic [2:0] rq, input logic [23:0] ad,
                              input logic [15:0] cnt, input logic [7:0] db,
                              input logic mi);
    sfce_pkg::res_t r;
    r_done = 1'b0; r_to = 1'b0; r_valid = 1'b0; r_byte = '0;
    if (rq == sfce_pkg::REQ_TICK) begin
      case (st)
        S_IDLE, S_WAITDATA: ;
        S_GAPCMD: begin
          p_csn = 1'b0;
          shift_load(p_op == sfce_pkg::REQ_ERASE ? sfce_pkg::CMD_SE : sfce_pkg::CMD_PP);
          st = S_CMD;
        end
        S_GAPPOLL: begin
          p_csn = 1'b0;
          shift_load(sfce_pkg::CMD_RDSR);
          st = S_POLLCMD;
        end
        default: begin
          if (!p_phase) begin
            p_sck = 1'b1;
            p_rx = {p_rx[6:0], mi};
            p_phase = 1'b1;
          end else begin
            p_sck = 1'b0;
            if (p_bit < 7) begin
              p_bit = p_bit + 3'd1;
              p_tx = {p_tx[6:0], 1'b0};
              p_mosi = p_tx[7];
              p_phase = 1'b0;
            end else byte_done();
          end
        end
      endcase
    end else if (rq == sfce_pkg::REQ_DATA) begin
      if (st == S_WAITDATA) begin
        shift_load(db);
        st = S_PDATA;
      end
    end else if (st == S_IDLE) begin
      p_op = rq; p_addr = ad; p_left = cnt;
      p_csn = 1'b0; p_sck = 1'b0;
      case (rq)
        sfce_pkg::REQ_ERASE, sfce_pkg::REQ_PROG, sfce_pkg::REQ_WREN: begin
          shift_load(sfce_pkg::CMD_WREN); st = S_ONEBYTE;
        end
        sfce_pkg::REQ_WRDI: begin shift_load(sfce_pkg::CMD_WRDI); st = S_ONEBYTE; end
        sfce_pkg::REQ_READ: begin shift_load(sfce_pkg::CMD_READ); st = S_CMD; end
        default: begin shift_load(sfce_pkg::CMD_RDSR); st = S_POLLCMD; end
      endcase
    end
    r.cs_n = p_csn; r.sck = p_sck; r.mosi = p_mosi;
    r.need_data = (st == S_WAITDATA);
    r.read_valid = r_valid; r.read_byte = r_byte;
    r.busy_res = (st != S_IDLE);
    r.done_res = r_done; r.timed_out = r_to;
    if (r_done) n_done++;
    if (r_to) n_timeout++;
    if (r_valid) n_rbytes++;
    pin_results_q.push_back(r);
  endtask

  // send one request, with random idle before it; valid stays up afterwards
  // and is dropped by the next idle gap or by drain
  task automatic send_req(input logic [2:0] rq, input logic [23:0] ad = '0,
                          input logic [15:0] cnt = '0, input logic [7:0] db = '0,
                          input logic mi = 1'b0);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rq; address <= ad; byte_count <= cnt;
    data_byte <= db; miso <= mi;
    @(posedge clk iff in_ready);
    predict_pins(rq, ad, cnt, db, mi);
    sent++;
  endtask

  // receiver stall control
  always @(posedge clk) begin
    if (hold_id != last_hold_id) begin
      last_hold_id <= hold_id;
      hold_cycles <= hold_len - 1;
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    sfce_pkg::res_t e;
    if (!rst && out_valid && out_ready) begin
      if (pin_results_q.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        e = pin_results_q.pop_front();
        checked++;
        if (cs_n !== e.cs_n) begin
          $error("cs_n exp %0h got %0h", e.cs_n, cs_n); errors++;
        end
        if (sck !== e.sck) begin
          $error("sck exp %0h got %0h", e.sck, sck); errors++;
        end
        if (mosi !== e.mosi) begin
          $error("mosi exp %0h got %0h", e.mosi, mosi); errors++;
        end
        if (need_data !== e.need_data) begin
          $error("need_data exp %0h got %0h", e.need_data, need_data); errors++;
        end
        if (read_valid !== e.read_valid) begin
          $error("read_valid exp %0h got %0h", e.read_valid, read_valid); errors++;
        end
        if (read_byte !== e.read_byte) begin
          $error("read_byte exp %0h got %0h", e.read_byte, read_byte); errors++;
        end
        if (busy_res !== e.busy_res) begin
          $error("busy_res exp %0h got %0h", e.busy_res, busy_res); errors++;
        end
        if (done_res !== e.done_res) begin
          $error("done_res exp %0h got %0h", e.done_res, done_res); errors++;
        end
        if (timed_out !== e.timed_out) begin
          $error("timed_out exp %0h got %0h", e.timed_out, timed_out); errors++;
        end
      end
    end
  end

  // stop sending, wait for every result, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pin_results_q.size() != 0) @(posedge clk);
    repeat (OpenLatency) @(posedge clk);
  endtask

  task automatic set_poll_limit(input logic [15:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    p_limit = v;
  endtask

  // tick until the engine is idle or waits for data; status byte from flash
  task automatic run_ticks(input logic [7:0] status, input bit rand_miso);
    while (st != S_IDLE && st != S_WAITDATA) begin
      if (st == S_POLL && p_phase == 1'b0)
        send_req(sfce_pkg::REQ_TICK, 24'($urandom), 16'($urandom), 8'($urandom),
                 rand_miso ? 1'($urandom) : status[7 - p_bit]);
      else
        send_req(sfce_pkg::REQ_TICK, 24'($urandom), 16'($urandom), 8'($urandom),
                 1'($urandom));
    end
  endtask

  // one whole flash operation with random content
  task automatic flash_op(input logic [2:0] rq, input logic [15:0] cnt,
                          input logic [7:0] status);
    send_req(rq, 24'($urandom), cnt, 8'($urandom), 1'($urandom));
    forever begin
      run_ticks(status, status == 8'hA5);
      if (st == S_IDLE) break;
      if ($urandom_range(9) == 0) send_req(sfce_pkg::REQ_TICK, 24'($urandom), 16'($urandom));
      send_req(sfce_pkg::REQ_DATA, 24'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
    end
  endtask

  task automatic test_directed();
    send_req(sfce_pkg::REQ_TICK, 24'hFFFFFF, 16'hFFFF, 8'hFF, 1'b1);
    send_req(sfce_pkg::REQ_DATA, '0, '0, 8'hFF);
    flash_op(sfce_pkg::REQ_WREN, 16'd0, 8'h00);
    flash_op(sfce_pkg::REQ_WRDI, 16'd0, 8'h00);
    flash_op(sfce_pkg::REQ_ERASE, 16'd0, 8'h00);
    flash_op(sfce_pkg::REQ_PROG, 16'd0, 8'h00);
    flash_op(sfce_pkg::REQ_PROG, 16'd1, 8'h00);
    flash_op(sfce_pkg::REQ_READ, 16'd0, 8'h00);
    flash_op(sfce_pkg::REQ_READ, 16'd2, 8'h00);
    // a read starts the engine; the erase sent while it is busy is ignored
    send_req(sfce_pkg::REQ_READ, 24'hFFFFFF, 16'd1, 8'h00);
    send_req(sfce_pkg::REQ_ERASE, 24'h000000, 16'hFFFF, 8'h00);
    flash_op(sfce_pkg::REQ_TICK, 16'd0, 8'h00);
    flash_op(sfce_pkg::REQ_WAIT, 16'd0, 8'h00);
  endtask

  // poll limit edges: always-busy status until the limit, then random and not-busy status
  task automatic test_poll_limits();
    set_poll_limit(16'd0);
    flash_op(sfce_pkg::REQ_WAIT, 16'd0, 8'hFF);
    set_poll_limit(16'd1);
    flash_op(sfce_pkg::REQ_WAIT, 16'd0, 8'hFF);
    set_poll_limit(16'd3);
    flash_op(sfce_pkg::REQ_WAIT, 16'd0, 8'hFF);
    flash_op(sfce_pkg::REQ_WAIT, 16'd0, 8'hA5);
    set_poll_limit(16'hFFFF);
    flash_op(sfce_pkg::REQ_WAIT, 16'd0, 8'h00);
    set_poll_limit(16'd4);
  endtask

  // random well-formed operations plus noise
  task automatic test_random(input int n_items, input int idle, input int stall);
    int stop_at;
    logic [2:0] rq;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    stop_at = sent + n_items;
    while (sent < stop_at) begin
      rq = 3'($urandom_range(7));
      if ($urandom_range(9) == 0) begin
        send_req(rq, 24'($urandom), 16'($urandom_range(3)), 8'($urandom), 1'($urandom));
      end else begin
        if (rq == sfce_pkg::REQ_DATA) rq = sfce_pkg::REQ_READ;
        flash_op(rq, 16'($urandom_range(3)), ($urandom_range(3) == 0) ? 8'h01 : 8'h00);
      end
    end
  endtask

  // long output hold so the queue fills and intake stalls
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_len = 60;
    hold_id = hold_id + 1;
    flash_op(sfce_pkg::REQ_READ, 16'd1, 8'h00);
  endtask

  initial begin
    st = S_IDLE; p_op = '0; p_tx = '0; p_rx = '0; p_bit = '0; p_phase = 1'b0;
    p_sck = 1'b0; p_mosi = 1'b0; p_csn = 1'b1; p_left = '0; p_polls = '0;
    p_addr = '0; p_limit = sfce_pkg::PollLimitReset;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_poll_limits();
    test_random(10, 0, 0);
    test_random(10, 52, 0);
    test_random(10, 0, 52);
    test_backpressure();
    test_random(10, 32, 32);
    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d requests, %0d results checked", sent, checked);
    $display("operations done %0d, poll timeouts %0d, read bytes %0d",
             n_done, n_timeout, n_rbytes);
    if (errors == 0 && pin_results_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
